>>> rtl/rrrs_pkg.sv
package rrrs_pkg;

  localparam int unsigned PORTS = 8;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  localparam int unsigned ADDR_RANGE_TOP    = 0;
  localparam int unsigned ADDR_ACTIVE_PORTS = 1;

  // Command broadcast from the controller to every storage cell.
  typedef struct packed {
    logic       ins;     // insert into this cell's buffer
    logic       clr;     // empty this cell's buffer
    logic [2:0] port;    // target cell
    logic [15:0] value;  // value to insert
  } cell_cmd_t;

endpackage

>>> rtl/rrrs_div.sv
// Restoring divider: one quotient bit per cycle.
module rrrs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [3:0]  divisor,
  output logic        busy,
  output logic [15:0] quot,
  output logic [3:0]  rem
);
  import rrrs_pkg::*;

  logic [15:0] q_r, q_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [3:0]  d_r, d_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [4:0]  trial;

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    d_nxt   = d_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, q_r[15]};
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      d_nxt   = divisor;
      cnt_nxt = 5'd16;
    end else if (cnt_r != 5'd0) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 4'(trial - {1'b0, d_r});
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[3:0];
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign busy = (cnt_r != 5'd0) || start;
  assign quot = q_r;
  assign rem  = rem_r;
endmodule

>>> rtl/rrrs_cell.sv
// One port's buffer: a row of entries, each comparing and shifting locally.
module rrrs_cell #(
  parameter int unsigned SEG_LEN = 16,
  parameter int unsigned IDX     = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrrs_pkg::cell_cmd_t  cmd,
  input  logic [$clog2(SEG_LEN)-1:0] rd_idx,
  output logic                 full,
  output logic [15:0]          head_value,
  output logic                 rd_valid,
  output logic [15:0]          rd_value,
  output logic [$clog2(SEG_LEN)-1:0] split
);
  import rrrs_pkg::*;
  localparam int unsigned IW = $clog2(SEG_LEN);

  logic [15:0]       val_r [SEG_LEN];
  logic [SEG_LEN-1:0] vld_r;
  logic [IW-1:0]     split_r;
  logic [SEG_LEN-1:0] gt;     // entry greater than new value (or empty in fill)
  logic [SEG_LEN-1:0] at_or_after;
  logic              sel;

  assign sel  = cmd.port == 3'(IDX);
  assign full = &vld_r;

  // Insertion position: first entry where gt is set, limited to split when full.
  always_comb begin
    for (int i = 0; i < SEG_LEN; i++) begin
      if (full)
        gt[i] = (IW'(i) <= split_r) &&
                ((IW'(i) == split_r) || (cmd.value < val_r[i]));
      else
        gt[i] = !vld_r[i] || (cmd.value < val_r[i]);
    end
    at_or_after[0] = gt[0];
    for (int i = 1; i < SEG_LEN; i++) at_or_after[i] = at_or_after[i-1] | gt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      split_r <= '0;
    end else if (cmd.clr && sel) begin
      vld_r   <= '0;
      split_r <= '0;
    end else if (cmd.ins && sel) begin
      if (at_or_after[0]) vld_r[0] <= 1'b1;
      for (int i = 1; i < SEG_LEN; i++) begin
        if (!full || IW'(i) <= split_r) begin
          if (at_or_after[i]) begin
            if (!at_or_after[i-1]) vld_r[i] <= 1'b1;
            else vld_r[i] <= vld_r[i-1];
          end
        end
      end
      if (full) split_r <= (split_r == IW'(SEG_LEN-1)) ? '0 : split_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && sel) begin
      if (at_or_after[0]) val_r[0] <= cmd.value;
      for (int i = 1; i < SEG_LEN; i++) begin
        if (!full || IW'(i) <= split_r) begin
          if (at_or_after[i]) begin
            if (!at_or_after[i-1]) val_r[i] <= cmd.value;
            else val_r[i] <= val_r[i-1];
          end
        end
      end
    end
  end

  assign head_value = val_r[split_r];
  assign rd_valid   = vld_r[rd_idx];
  assign rd_value   = val_r[rd_idx];
  assign split      = split_r;
endmodule

>>> rtl/range_routed_run_sorter.sv
// range_routed_run_sorter
// Values enter on the in_ channel (in_mode 0 inserts in_value, in_mode 1
// drains port in_drain_port). Results leave on the out_ channel, one per
// insert and one per valid entry on a drain (or a single empty result).
// out_last marks the final result of each item.
// An insert is routed (range compare) when it is accepted and then writes
// its port's buffer once the output register is free; its result sits in
// the output register. A drain walks the port's buffer one entry per cycle
// while the output is free, through the one read path into the cell row.
// Configuration writes through the cfg_ APB port re-run the range split:
// a bit-serial divide of the range top by the port count (a start state,
// 16 quotient steps and a check that the divider has finished), then the
// range starts are formed one port per cycle. No item is accepted meanwhile.
// The same sequence runs after reset before the block first takes an item.
// When out_ready is low the result holds in the output register and no new
// item is accepted until it is transferred.
// All ports come out of reset empty with their split index at zero.
module range_routed_run_sorter #(
  parameter int unsigned SEG_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_value,
  input  logic [2:0]  in_drain_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_port,
  output logic        out_has_value,
  output logic [15:0] out_value,
  output logic        out_out_of_range,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rrrs_pkg::*;
  localparam int unsigned IW = $clog2(SEG_LEN);
  localparam int unsigned PW = $clog2(PORTS);

  localparam logic [2:0] ST_DIV   = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_IDLE  = 3'd2;
  localparam logic [2:0] ST_INS   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_START = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [15:0] maxv_r;
  logic [3:0]  act_r;
  logic [3:0]  eff;
  logic        cfg_wr;

  // Output register.
  logic        ov_r, ov_nxt;
  logic [2:0]  op_r;
  logic        oh_r, oo_r, ol_r;
  logic [15:0] oval_r;

  // Range table, filled one port per cycle after the divide.
  logic [15:0] start_r [PORTS];
  logic [15:0] acc_r;
  logic [PW:0] rp_r;
  logic [15:0] q;
  logic [3:0]  r;
  logic        dbusy, dstart;

  // Item hold. For an insert, dp_r holds the routed port and oor_r flags
  // a value above the range top.
  logic [15:0] iv_r;
  logic [2:0]  dp_r;
  logic [IW:0] dk_r;
  logic [PW-1:0] route_sel;
  logic        oor_r;

  // Drain walk: an entry's result is held back one step so the last flag
  // can be set on it once the walk ends.
  logic        pend_r;
  logic [15:0] pval_r;

  cell_cmd_t cmd;
  logic [PORTS-1:0] full;
  logic [15:0] head [PORTS];
  logic [PORTS-1:0] rdv;
  logic [15:0] rdval [PORTS];
  logic [IW-1:0] splt [PORTS];
  logic [IW-1:0] rd_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == 1'(ADDR_ACTIVE_PORTS)) ? {28'd0, act_r}
                                                              : {16'd0, maxv_r};
  assign eff = (act_r == 4'd0) ? 4'd1 : (act_r > 4'(PORTS)) ? 4'(PORTS) : act_r;
  assign dstart = (st_r == ST_START);

  rrrs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(maxv_r), .divisor(eff),
    .busy(dbusy), .quot(q), .rem(r)
  );

  genvar g;
  generate
    for (g = 0; g < PORTS; g++) begin : g_cell
      rrrs_cell #(.SEG_LEN(SEG_LEN), .IDX(g)) u_cell (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rd_idx(rd_idx), .full(full[g]),
        .head_value(head[g]), .rd_valid(rdv[g]), .rd_value(rdval[g]),
        .split(splt[g])
      );
    end
  endgenerate

  // Route: the highest active port whose start is not above the value.
  // Empty ranges share a start with the next port, so the last match wins,
  // and the final port catches the tail above the last start.
  always_comb begin
    route_sel = '0;
    for (int p = 0; p < PORTS; p++) begin
      if (p < eff && in_value >= start_r[p]) route_sel = PW'(p);
    end
  end

  // Walk index wraps at SEG_LEN, starting from the split.
  logic dp_ok;
  logic [IW-1:0] dr_idx;
  logic [IW:0]   rd_sum;
  assign dp_ok  = {1'b0, dp_r} < 4'(PORTS);
  assign rd_sum = {1'b0, splt[dp_r[PW-1:0]]} + {1'b0, dk_r[IW-1:0]};
  assign dr_idx = (rd_sum >= (IW+1)'(SEG_LEN)) ? IW'(rd_sum - (IW+1)'(SEG_LEN))
                                               : rd_sum[IW-1:0];
  assign rd_idx = dr_idx;

  logic out_free;
  assign out_free = !ov_r || out_ready;
  assign in_ready = (st_r == ST_IDLE) && out_free;

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    cmd.value = iv_r;
    cmd.port  = dp_r;
    case (st_r)
      ST_START: st_nxt = ST_DIV;
      ST_DIV:   if (!dbusy) st_nxt = ST_RANGE;
      ST_RANGE: if (rp_r == (PW+1)'(PORTS-1)) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid && in_ready) st_nxt = (in_mode == MODE_DRAIN) ? ST_DRAIN : ST_INS;
      end
      ST_INS: begin
        if (out_free) begin
          // Drop an out-of-range value: it touches no buffer.
          cmd.ins = !oor_r;
          st_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (!dp_ok) begin
          if (out_free) st_nxt = ST_IDLE;
        end else if (dk_r == (IW+1)'(SEG_LEN)) begin
          if (out_free) begin
            cmd.clr = 1'b1;
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_START;
    endcase
    if (cfg_wr) st_nxt = ST_START;
  end

  // Hold the result until transferred; load it when a step produces one.
  always_comb begin
    ov_nxt = ov_r && !out_ready;
    if (st_r == ST_INS && out_free) ov_nxt = 1'b1;
    if (st_r == ST_DRAIN && out_free) begin
      if (!dp_ok || dk_r == (IW+1)'(SEG_LEN)) ov_nxt = 1'b1;
      else if (rdv[dp_r[PW-1:0]] && pend_r) ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_START;
      maxv_r <= 16'hFFFF;
      act_r  <= 4'd8;
      ov_r   <= 1'b0;
      rp_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr && cfg_paddr[2] == 1'(ADDR_RANGE_TOP)) maxv_r <= cfg_pwdata[15:0];
      if (cfg_wr && cfg_paddr[2] == 1'(ADDR_ACTIVE_PORTS)) act_r <= cfg_pwdata[3:0];
      ov_r <= ov_nxt;
      if (st_r == ST_DIV) rp_r <= '0;
      if (st_r == ST_RANGE) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_DIV: acc_r <= '0;
      ST_RANGE: begin
        start_r[rp_r[PW-1:0]] <= acc_r;
        acc_r <= acc_r + q + (({1'b0, rp_r} < 5'(r)) ? 16'd1 : 16'd0);
      end
      ST_IDLE: begin
        iv_r <= in_value;
        oor_r <= in_value > maxv_r;
        dp_r <= (in_mode == MODE_DRAIN) ? in_drain_port : 3'(route_sel);
        dk_r <= '0;
        pend_r <= 1'b0;
      end
      ST_INS: begin
        if (out_free) begin
          op_r <= oor_r ? 3'd0 : dp_r;
          oh_r <= !oor_r && full[dp_r[PW-1:0]];
          oval_r <= (!oor_r && full[dp_r[PW-1:0]]) ? head[dp_r[PW-1:0]] : 16'd0;
          oo_r <= oor_r;
          ol_r <= 1'b1;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          op_r <= dp_r;
          oo_r <= 1'b0;
          if (!dp_ok || dk_r == (IW+1)'(SEG_LEN)) begin
            oh_r <= pend_r;
            oval_r <= pend_r ? pval_r : 16'd0;
            ol_r <= 1'b1;
          end else begin
            dk_r <= dk_r + 1'b1;
            if (rdv[dp_r[PW-1:0]]) begin
              pend_r <= 1'b1;
              pval_r <= rdval[dp_r[PW-1:0]];
              oh_r <= 1'b1;
              oval_r <= pval_r;
              ol_r <= 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_port = op_r;
  assign out_has_value = oh_r;
  assign out_value = oval_r;
  assign out_out_of_range = oo_r;
  assign out_last = ol_r;
endmodule

>>> rtl/rrrs_checker.sv
module rrrs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_has_value,
  input logic [15:0] out_value,
  input logic out_out_of_range,
  input logic out_last
);
  a_oor_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_last && !out_has_value) else $error("oor");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_value |-> out_value == 16'd0) else $error("zero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("hold");
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("stall");
endmodule

bind range_routed_run_sorter rrrs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_has_value(out_has_value),
  .out_value(out_value), .out_out_of_range(out_out_of_range), .out_last(out_last)
);

>>> verif/testbench.sv
module testbench;
  import rrrs_pkg::*;

  localparam int unsigned NPORTS   = 8;
  localparam int unsigned DEPTH    = 16;
  localparam int unsigned LIMIT    = 400000;
  localparam int unsigned SETTLE   = 40;   // covers a full drain walk plus margin
  localparam int unsigned LONG_OFF = 300;  // receiver hold-off to back up the block

  typedef struct {
    logic        mode;
    logic [15:0] value;
    logic [2:0]  drain_port;
  } cmd_t;

  typedef struct {
    logic [2:0]  port;
    logic        has_value;
    logic [15:0] value;
    logic        out_of_range;
    logic        last;
  } emission_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = MODE_INSERT;
  logic [15:0] in_value = '0;
  logic [2:0]  in_drain_port = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_port;
  logic        out_has_value;
  logic [15:0] out_value;
  logic        out_out_of_range;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  range_routed_run_sorter u_top (.*);

  // Shadow copy of the sorter: configuration plus per-port buffers.
  logic [15:0] sh_range_top = 16'd65535;
  logic [3:0]  sh_active = 4'd8;
  logic [15:0] buf_val [NPORTS][DEPTH];
  logic        buf_vld [NPORTS][DEPTH];
  int unsigned fill_left [NPORTS];
  int unsigned split_at [NPORTS];

  cmd_t        cmd_queue[$];
  emission_t   expected_emissions[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned rx_count = 0;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL range_routed_run_sorter");
      $finish;
    end
  end

  function automatic int unsigned live_ports();
    if (sh_active < 1) return 1;
    if (sh_active > NPORTS) return NPORTS;
    return sh_active;
  endfunction

  // Map an in-range value onto its port: first r ports are one value wider.
  function automatic int unsigned port_of(int unsigned v);
    int unsigned a, q, r, start, width;
    a = live_ports();
    q = sh_range_top / a;
    r = sh_range_top % a;
    for (int unsigned p = 0; p + 1 < a; p++) begin
      width = (p < r) ? q + 1 : q;
      start = (p < r) ? p * (q + 1) : r * (q + 1) + (p - r) * q;
      if (v >= start && v - start < width) return p;
    end
    return a - 1;
  endfunction

  function automatic void clear_port(int unsigned p);
    for (int unsigned i = 0; i < DEPTH; i++) begin
      buf_vld[p][i] = 1'b0;
      buf_val[p][i] = '0;
    end
    fill_left[p] = DEPTH;
    split_at[p] = 0;
  endfunction

  function automatic void push_emission(logic [2:0] port, logic hv, logic [15:0] val,
                                        logic oor, logic lst);
    emission_t e;
    e.port = port;
    e.has_value = hv;
    e.value = val;
    e.out_of_range = oor;
    e.last = lst;
    expected_emissions.push_back(e);
  endfunction

  // Apply one accepted command to the shadow buffers and queue its emissions.
  function automatic void sort_and_route(cmd_t c);
    int unsigned p, idx, sp, n;
    logic [15:0] old;
    if (c.mode == MODE_INSERT) begin
      if (c.value > sh_range_top) begin
        push_emission(3'd0, 1'b0, 16'd0, 1'b1, 1'b1);
        return;
      end
      p = port_of(c.value);
      if (fill_left[p] > 0) begin
        idx = DEPTH - 1;
        for (int unsigned i = 0; i < DEPTH; i++)
          if (!buf_vld[p][i] || c.value < buf_val[p][i]) begin
            idx = i;
            break;
          end
        for (int unsigned i = DEPTH - 1; i > idx; i--) begin
          buf_val[p][i] = buf_val[p][i-1];
          buf_vld[p][i] = buf_vld[p][i-1];
        end
        buf_val[p][idx] = c.value;
        buf_vld[p][idx] = 1'b1;
        fill_left[p]--;
        push_emission(p[2:0], 1'b0, 16'd0, 1'b0, 1'b1);
      end else begin
        // Full buffer: emit the old-run head, slot the new value at or before the split.
        sp = split_at[p];
        old = buf_val[p][sp];
        idx = sp;
        for (int unsigned i = 0; i < sp; i++)
          if (c.value < buf_val[p][i]) begin
            idx = i;
            break;
          end
        for (int unsigned i = sp; i > idx; i--) buf_val[p][i] = buf_val[p][i-1];
        buf_val[p][idx] = c.value;
        buf_vld[p][idx] = 1'b1;
        split_at[p] = (sp + 1) % DEPTH;
        push_emission(p[2:0], 1'b1, old, 1'b0, 1'b1);
      end
    end else begin
      p = c.drain_port;
      sp = split_at[p];
      n = 0;
      for (int unsigned k = 0; k < DEPTH; k++) begin
        idx = (sp + k) % DEPTH;
        if (buf_vld[p][idx]) begin
          push_emission(p[2:0], 1'b1, buf_val[p][idx], 1'b0, 1'b0);
          n++;
        end
      end
      clear_port(p);
      if (n == 0) push_emission(p[2:0], 1'b0, 16'd0, 1'b0, 1'b1);
      else expected_emissions[expected_emissions.size()-1].last = 1'b1;
    end
  endfunction

  // Driver: present queued commands with random gaps, bursts without gaps.
  int unsigned tx_gap = 0;
  bit tx_burst = 0;
  always @(posedge clk) begin
    cmd_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) sort_and_route('{in_mode, in_value, in_drain_port});
      if ($urandom_range(0, 60) == 0) tx_burst = ~tx_burst;
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          nxt = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_value <= nxt.value;
          in_drain_port <= nxt.drain_port;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each transfer against the oldest expectation, stall at random.
  int unsigned rx_stall = 0;
  bit rx_burst = 0;
  always @(posedge clk) begin
    emission_t e;
    if (rst_n) begin
      if ($urandom_range(0, 50) == 0) rx_burst = ~rx_burst;
      if (out_valid && out_ready) begin
        rx_count++;
        if (expected_emissions.size() == 0) begin
          $error("unexpected transfer: port %0d value %0d", out_port, out_value);
          mismatches++;
        end else begin
          e = expected_emissions.pop_front();
          if (out_port !== e.port) begin
            $error("out_port expected %0d actual %0d", e.port, out_port);
            mismatches++;
          end
          if (out_has_value !== e.has_value) begin
            $error("has_value expected %0d actual %0d", e.has_value, out_has_value);
            mismatches++;
          end
          if (out_value !== e.value) begin
            $error("out_value expected %0d actual %0d", e.value, out_value);
            mismatches++;
          end
          if (out_out_of_range !== e.out_of_range) begin
            $error("out_of_range expected %0d actual %0d", e.out_of_range, out_out_of_range);
            mismatches++;
          end
          if (out_last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, out_last);
            mismatches++;
          end
        end
        // Hold off once for a long stretch so the block backs up into its input.
        rx_stall = (rx_count == 60) ? LONG_OFF : (rx_burst ? 0 : $urandom_range(0, 17));
        out_ready <= (rx_stall == 0);
      end else if (!out_ready) begin
        if (rx_stall > 1) rx_stall--;
        else begin
          rx_stall = 0;
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic reg_write(int unsigned idx, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * idx);
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == ADDR_RANGE_TOP) sh_range_top = data[15:0];
    else if (idx == ADDR_ACTIVE_PORTS) sh_active = data[3:0];
  endtask

  // Wait until every command is in and every emission has been checked.
  task automatic wait_drained();
    while (cmd_queue.size() > 0 || in_valid || expected_emissions.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void add_cmd(logic mode, logic [15:0] value, logic [2:0] dp);
    cmd_t c;
    c.mode = mode;
    c.value = value;
    c.drain_port = dp;
    cmd_queue.push_back(c);
  endfunction

  // Mostly in-range inserts that fill and roll the buffers; some drains, some noise.
  function automatic void add_random(int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        add_cmd(MODE_DRAIN, 16'($urandom), 3'($urandom_range(0, 7)));
      else if (pick < 16 && sh_range_top != 16'hffff)
        add_cmd(MODE_INSERT, 16'($urandom_range(sh_range_top + 1, 65535)), 3'($urandom));
      else if (pick < 24)
        add_cmd(MODE_INSERT, 16'($urandom), 3'($urandom));
      else
        add_cmd(MODE_INSERT, 16'($urandom_range(0, sh_range_top)), 3'($urandom));
    end
  endfunction

  initial begin
    for (int unsigned p = 0; p < NPORTS; p++) clear_port(p);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, both modes, empty drain, fill then roll port 0.
    add_cmd(MODE_INSERT, 16'd0, 3'd0);
    add_cmd(MODE_INSERT, 16'hffff, 3'd7);
    add_cmd(MODE_INSERT, 16'd8192, 3'd0);
    add_cmd(MODE_INSERT, 16'd32768, 3'd0);
    add_cmd(MODE_DRAIN, 16'hffff, 3'd7);
    add_cmd(MODE_DRAIN, 16'd0, 3'd3);
    for (int unsigned i = 0; i < 18; i++)
      add_cmd(MODE_INSERT, 16'((i * 2731) % 8192), 3'd0);
    add_cmd(MODE_DRAIN, 16'd0, 3'd0);
    wait_drained();

    // Narrow range over two ports; pause the sender midway.
    reg_write(ADDR_RANGE_TOP, 32'd1000);
    reg_write(ADDR_ACTIVE_PORTS, 32'd2);
    add_random(40);
    wait_drained();
    add_random(40);
    wait_drained();

    // Fewer values than ports: only the first ports and the last one get values.
    reg_write(ADDR_RANGE_TOP, 32'd3);
    reg_write(ADDR_ACTIVE_PORTS, 32'd8);
    add_random(40);
    wait_drained();

    reg_write(ADDR_RANGE_TOP, 32'd1);
    reg_write(ADDR_ACTIVE_PORTS, 32'd1);
    add_random(40);
    wait_drained();

    reg_write(ADDR_RANGE_TOP, 32'd40000);
    reg_write(ADDR_ACTIVE_PORTS, 32'd5);
    add_random(30);
    wait_drained();

    reg_write(ADDR_RANGE_TOP, 32'd65535);
    reg_write(ADDR_ACTIVE_PORTS, 32'd8);
    add_random(40);
    for (int unsigned p = 0; p < NPORTS; p++) add_cmd(MODE_DRAIN, 16'd0, 3'(p));
    wait_drained();

    if (mismatches == 0 && expected_emissions.size() == 0)
      $display("PASS range_routed_run_sorter");
    else
      $display("FAIL range_routed_run_sorter");
    $finish;
  end

endmodule
